/* rtl/arrival_order_spacing_scheduler_defines.svh */
// Assertion macros shared by the arrival-order spacing scheduler RTL.
`ifndef ARRIVAL_ORDER_SPACING_SCHEDULER_DEFINES_SVH
`define ARRIVAL_ORDER_SPACING_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define AOSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aoss same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define AOSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aoss next-cycle check failed");

`endif

/* rtl/aoss_pkg.sv */
// Types and constants shared by the arrival-order spacing scheduler.
package aoss_pkg;

  localparam int CP_W     = 16;
  localparam int GROUP_W  = 6;
  localparam int TIME_W   = 63;
  localparam int SEQ_W    = 6;
  localparam int ORDER_W  = 7;
  localparam int GCOUNT_W = 7;
  localparam int SPACE_W  = 40;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Configuration register indexes.
  localparam logic CFG_GROUP_COUNT = 1'b0;
  localparam logic CFG_MIN_GAP     = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_INVALID = 2'd1,
    ST_DOUBLE  = 2'd2
  } status_t;

  // One reservation request.
  typedef struct packed {
    logic [TIME_W-1:0]  arrival_time;
    logic [GROUP_W-1:0] group;
    logic [CP_W-1:0]    checkpoint;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [TIME_W-1:0] wait_time;
    logic [SEQ_W-1:0]  sequence_res;
    logic [TIME_W-1:0] scheduled_time;
    status_t           status;
  } res_t;

  // Round state as seen by the current request, after any round restart.
  typedef struct packed {
    logic               seen;
    logic               last_valid;
    logic [TIME_W-1:0]  last_start;
    logic [ORDER_W-1:0] next_order;
  } round_view_t;

endpackage

/* rtl/aoss_sched.sv */
// Grant decision and start-time computation for one reservation request.
module aoss_sched (
  input  aoss_pkg::req_t                    req,
  input  logic                              group_ok,
  input  aoss_pkg::round_view_t             view,
  input  logic [aoss_pkg::SPACE_W-1:0]      min_gap,
  output aoss_pkg::res_t                    res,
  output logic                              grant
);
  import aoss_pkg::*;

  logic [TIME_W:0]   earliest_sum;
  logic [TIME_W-1:0] earliest;
  logic [TIME_W-1:0] sched;

  // Earliest slot after the previous grant, saturated at the largest time.
  always_comb begin
    earliest_sum = {1'b0, view.last_start} + {{(TIME_W + 1 - SPACE_W){1'b0}}, min_gap};
    earliest     = earliest_sum[TIME_W] ? TIME_MAX : earliest_sum[TIME_W-1:0];
    if (!view.last_valid) begin
      sched = req.arrival_time;
    end else begin
      sched = (req.arrival_time > earliest) ? req.arrival_time : earliest;
    end
  end

  // Status and result fields; rejected requests carry zeros.
  always_comb begin
    res   = '0;
    grant = 1'b0;
    priority if (!group_ok) begin
      res.status = ST_INVALID;
    end else if (view.seen) begin
      res.status = ST_DOUBLE;
    end else begin
      grant              = 1'b1;
      res.status         = ST_GRANTED;
      res.scheduled_time = sched;
      res.sequence_res   = view.next_order[SEQ_W-1:0];
      res.wait_time      = sched - req.arrival_time;
    end
  end

endmodule

/* rtl/arrival_order_spacing_scheduler.sv */
// Requests pass the input stage register, then the result register when it can take data.
// Throughput: one request per cycle unless m_tready stalls; the round state (seen map,
// order counter, last start) is read and updated as a request leaves the input stage.
// Reset: synchronous rst clears the round, the seen map and both stream stages,
// and loads group_count with 64 and min_gap with 0.
module arrival_order_spacing_scheduler #(
  parameter int MAX_GROUPS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] checkpoint, [21:16] group, [84:22] arrival_time, [87:85] zero
  input  logic [87:0]                    s_tdata,
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [64:2] scheduled_time, [70:65] sequence_res, [133:71] wait_time,
  // [135:134] zero
  output logic [135:0]                   m_tdata,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [aoss_pkg::SPACE_W-1:0]   cfg_data
);
  import aoss_pkg::*;

  `include "arrival_order_spacing_scheduler_defines.svh"

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Configuration registers.
  logic [GCOUNT_W-1:0] group_count;
  logic [SPACE_W-1:0]  min_gap;

  // Input and result stages.
  logic        in_valid;
  req_t        in_req;
  logic        out_valid;
  res_t        out_res;
  logic        advance;

  // Round state.
  logic [MAX_GROUPS-1:0] seen_map;
  logic                  round_valid;
  logic [CP_W-1:0]       round_id;
  logic [ORDER_W-1:0]    next_order;
  logic [TIME_W-1:0]     last_start;
  logic                  last_valid;

  logic              group_ok;
  logic              new_round;
  logic [GW+GROUP_W-1:0] grp_ext;
  logic [GW-1:0]     grp_idx;
  round_view_t       view;
  res_t              res;
  logic              grant;
  logic              update;

  // Stage handshakes: the pipeline moves when the result register can take data.
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign cfg_ready = 1'b1;

  assign m_tdata = {2'b00, out_res.wait_time, out_res.sequence_res,
                    out_res.scheduled_time, out_res.status};

  // Group range check and round lookup for the request in the input stage.
  always_comb begin
    grp_ext   = {{GW{1'b0}}, in_req.group};
    grp_idx   = grp_ext[GW-1:0];
    group_ok  = ({1'b0, in_req.group} < group_count) &&
                ({{(32 - GROUP_W){1'b0}}, in_req.group} < 32'(MAX_GROUPS));
    new_round = !round_valid || (round_id != in_req.checkpoint);
    view.seen       = new_round ? 1'b0 : seen_map[grp_idx];
    view.last_valid = new_round ? 1'b0 : last_valid;
    view.last_start = last_start;
    view.next_order = new_round ? '0 : next_order;
  end

  aoss_sched u_sched (
    .req        (in_req),
    .group_ok   (group_ok),
    .view       (view),
    .min_gap    (min_gap),
    .res        (res),
    .grant      (grant)
  );

  assign update = in_valid && advance && grant;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= GCOUNT_W'(64);
      min_gap     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GROUP_COUNT: group_count <= cfg_data[GCOUNT_W-1:0];
        CFG_MIN_GAP:     min_gap     <= cfg_data;
      endcase
    end
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_req <= req_t'(s_tdata[84:0]);
    end
  end

  // Result stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  // Round state update on a grant; a new round clears the map first.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_map    <= '0;
      round_valid <= 1'b0;
      round_id    <= '0;
      next_order  <= '0;
      last_start  <= '0;
      last_valid  <= 1'b0;
    end else if (update) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        seen_map[i] <= (new_round ? 1'b0 : seen_map[i]) || (grp_idx == GW'(i));
      end
      round_valid <= 1'b1;
      round_id    <= in_req.checkpoint;
      next_order  <= view.next_order + ORDER_W'(1);
      last_start  <= res.scheduled_time;
      last_valid  <= 1'b1;
    end
  end

  // Checks on this block's own logic.
  `AOSS_ASSERT_NOW(a_reject_zero, m_tvalid && (out_res.status != ST_GRANTED),
    (out_res.scheduled_time == '0) && (out_res.sequence_res == '0) && (out_res.wait_time == '0))
  `AOSS_ASSERT_NOW(a_delay_bound, m_tvalid && (out_res.status == ST_GRANTED),
    out_res.wait_time <= out_res.scheduled_time)
  `AOSS_ASSERT_NEXT(a_grant_sets_round, update, round_valid && last_valid && (seen_map != '0))
  `AOSS_ASSERT_NOW(a_order_bound, 1'b1, next_order <= ORDER_W'(64))
  `AOSS_ASSERT_NOW(a_stall_blocks_input, in_valid && !advance, !s_tready)

endmodule
